// ----- design/wsled_pkg.sv -----
// Shared types and constants for the WS2812 LED chain driver.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package wsled_pkg;

   // Default size of the pixel store.
   localparam int MAX_LEDS_DEF = 256;

   // Bits per pixel on the wire: green, red, blue, eight bits each.
   localparam int BITS_PER_PIXEL = 24;

   // Configuration register indexes.
   localparam int CSR_IW = 3;
   localparam int CSR_DW = 16;
   localparam logic [CSR_IW-1:0] CSR_LED_COUNT       = 3'd0;
   localparam logic [CSR_IW-1:0] CSR_ONE_HIGH_TICKS  = 3'd1;
   localparam logic [CSR_IW-1:0] CSR_ONE_LOW_TICKS   = 3'd2;
   localparam logic [CSR_IW-1:0] CSR_ZERO_HIGH_TICKS = 3'd3;
   localparam logic [CSR_IW-1:0] CSR_ZERO_LOW_TICKS  = 3'd4;
   localparam logic [CSR_IW-1:0] CSR_LATCH_TICKS     = 3'd5;

   // Configuration reset values.
   localparam logic [8:0]  LED_COUNT_RST       = 9'd16;
   localparam logic [15:0] ONE_HIGH_TICKS_RST  = 16'd16;
   localparam logic [15:0] ONE_LOW_TICKS_RST   = 16'd9;
   localparam logic [15:0] ZERO_HIGH_TICKS_RST = 16'd8;
   localparam logic [15:0] ZERO_LOW_TICKS_RST  = 16'd17;
   localparam logic [15:0] LATCH_TICKS_RST     = 16'd5700;

   // Request command codes.
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_SEND  = 2'd1,
      CMD_LATCH = 2'd2,
      CMD_TICK  = 2'd3
   } cmd_type;

   // Line sequencer phase.
   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_SEND  = 2'd1,
      PH_LATCH = 2'd2
   } phase_type;

   // Configuration registers as seen by the serializer.
   typedef struct packed {
      logic [8:0]  led_count;
      logic [15:0] one_high_ticks;
      logic [15:0] one_low_ticks;
      logic [15:0] zero_high_ticks;
      logic [15:0] zero_low_ticks;
      logic [15:0] latch_ticks;
   } cfg_type;

   // Serializer status toward the top level.
   typedef struct packed {
      logic busy;        // a frame or latch period is running now
      logic pin_next;    // line level after the request being accepted
      logic busy_next;   // busy flag after the request being accepted
   } stat_type;

endpackage

`default_nettype wire

// ----- design/wsled_pixel_mem.sv -----
// Pixel store: one write port and one registered read port, GRB words.
// Depends on wsled_pkg for its default depth; no submodules.
`default_nettype none

module wsled_pixel_mem #(
   parameter int DEPTH = wsled_pkg::MAX_LEDS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [23:0]   wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [23:0]   rd_data
);

   logic [23:0] mem_ff [DEPTH];
   logic [23:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port; data holds until the next read.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- design/wsled_serializer.sv -----
// Line sequencer: decodes requests, times the high and low segments and
// prefetches the next pixel from the pixel store. Depends on wsled_pkg.
`default_nettype none

module wsled_serializer #(
   parameter int MAX_LEDS = wsled_pkg::MAX_LEDS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_fire,
   input  wire logic [1:0]            req_command,
   input  wire logic [7:0]            req_led_index,
   input  wire logic [23:0]           req_color,
   input  wire wsled_pkg::cfg_type    cfg,
   input  wire logic [23:0]           rd_data,
   output logic                       wr_en,
   output logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] wr_addr,
   output logic [23:0]                wr_data,
   output logic                       rd_en,
   output logic [((MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1)-1:0] rd_addr,
   output wsled_pkg::stat_type        stat
);

   import wsled_pkg::*;

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
   localparam int PW = $clog2(MAX_LEDS + 1);
   localparam logic [4:0] LAST_BIT = 5'(BITS_PER_PIXEL - 1);

   // A zero duration register counts as one tick.
   function automatic logic [15:0] dur(input logic [15:0] t);
      return (t == 16'd0) ? 16'd1 : t;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [PW-1:0] ptr_ff, ptr_in;
   logic [4:0]  bitpos_ff, bitpos_in;
   logic [15:0] cnt_ff, cnt_in;
   logic        line_ff, line_in;
   logic [23:0] cur_pix_ff, cur_pix_in;
   logic [23:0] pix0_ff, pix0_in;

   logic [PW-1:0] eff_cnt;
   logic [PW:0]   new_ptr;
   logic [PW:0]   fetch_idx;
   logic [15:0]   cnt_dec;
   logic [23:0]   grb;
   logic          busy, is_tick, seg_end, last_bit, frame_end;
   logic          start_send, start_latch, do_write, pix_adv;

   // Effective chain length, clamped to the store size.
   assign eff_cnt = (32'(cfg.led_count) > MAX_LEDS) ? PW'(MAX_LEDS) : PW'(cfg.led_count);

   // Request decode.
   assign busy        = (phase_ff != PH_IDLE);
   assign is_tick     = req_fire && (req_command == CMD_TICK);
   assign start_send  = req_fire && (req_command == CMD_SEND) && !busy
                        && (cfg.led_count != 9'd0);
   assign start_latch = req_fire && (req_command == CMD_LATCH) && !busy;
   assign do_write    = req_fire && (req_command == CMD_WRITE) && !busy
                        && (32'(req_led_index) < 32'(eff_cnt));
   assign grb         = {req_color[15:8], req_color[23:16], req_color[7:0]};

   // Segment and frame bookkeeping.
   assign cnt_dec   = (cnt_ff != 16'd0) ? (cnt_ff - 16'd1) : 16'd0;
   assign seg_end   = (cnt_dec == 16'd0);
   assign last_bit  = (bitpos_ff == LAST_BIT);
   assign new_ptr   = last_bit ? ({1'b0, ptr_ff} + (PW+1)'(1)) : {1'b0, ptr_ff};
   assign frame_end = (new_ptr >= {1'b0, eff_cnt});
   assign pix_adv   = is_tick && (phase_ff == PH_SEND) && seg_end && !line_ff
                      && !frame_end && last_bit;

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         PH_IDLE: begin
            if (start_send) begin
               phase_in = PH_SEND;
            end else if (start_latch) begin
               phase_in = PH_LATCH;
            end
         end
         PH_SEND: begin
            if (is_tick && seg_end && !line_ff && frame_end) begin
               phase_in = PH_IDLE;
            end
         end
         PH_LATCH: begin
            if (is_tick && seg_end) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Datapath: pointer, bit position, segment counter, line level, pixels.
   always_comb begin
      ptr_in     = ptr_ff;
      bitpos_in  = bitpos_ff;
      cnt_in     = cnt_ff;
      line_in    = line_ff;
      cur_pix_in = cur_pix_ff;
      pix0_in    = pix0_ff;
      if (start_send) begin
         ptr_in     = '0;
         bitpos_in  = 5'd0;
         line_in    = 1'b1;
         cur_pix_in = pix0_ff;
         cnt_in     = dur(pix0_ff[23] ? cfg.one_high_ticks : cfg.zero_high_ticks);
      end else if (start_latch) begin
         line_in = 1'b0;
         cnt_in  = dur(cfg.latch_ticks);
      end else if (is_tick && (phase_ff == PH_LATCH)) begin
         cnt_in = cnt_dec;
      end else if (is_tick && (phase_ff == PH_SEND)) begin
         if (!seg_end) begin
            cnt_in = cnt_dec;
         end else if (line_ff) begin
            line_in = 1'b0;
            cnt_in  = dur(cur_pix_ff[23] ? cfg.one_low_ticks : cfg.zero_low_ticks);
         end else if (frame_end) begin
            line_in   = 1'b0;
            ptr_in    = '0;
            bitpos_in = 5'd0;
            cnt_in    = 16'd0;
         end else if (last_bit) begin
            // Move to the prefetched pixel.
            bitpos_in  = 5'd0;
            ptr_in     = ptr_ff + PW'(1);
            cur_pix_in = rd_data;
            line_in    = 1'b1;
            cnt_in     = dur(rd_data[23] ? cfg.one_high_ticks : cfg.zero_high_ticks);
         end else begin
            bitpos_in  = bitpos_ff + 5'd1;
            cur_pix_in = {cur_pix_ff[22:0], 1'b0};
            line_in    = 1'b1;
            cnt_in     = dur(cur_pix_ff[22] ? cfg.one_high_ticks : cfg.zero_high_ticks);
         end
      end
      // Pixel zero is shadowed so that a send can start without a read.
      if (do_write && (req_led_index == 8'd0)) begin
         pix0_in = grb;
      end
   end

   // Store accesses. Writes never happen during a frame, so a prefetched
   // pixel cannot go stale.
   assign wr_en     = do_write;
   assign wr_addr   = AW'(req_led_index);
   assign wr_data   = grb;
   assign fetch_idx = start_send ? (PW+1)'(1) : ({1'b0, ptr_ff} + (PW+1)'(2));
   assign rd_en     = (start_send || pix_adv) && (fetch_idx < (PW+1)'(MAX_LEDS));
   assign rd_addr   = AW'(fetch_idx);

   // Status toward the top level.
   assign stat.busy      = busy;
   assign stat.pin_next  = line_in;
   assign stat.busy_next = (phase_in != PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         ptr_ff     <= '0;
         bitpos_ff  <= 5'd0;
         cnt_ff     <= 16'd0;
         line_ff    <= 1'b0;
         cur_pix_ff <= 24'd0;
         pix0_ff    <= 24'd0;
      end else begin
         phase_ff   <= phase_in;
         ptr_ff     <= ptr_in;
         bitpos_ff  <= bitpos_in;
         cnt_ff     <= cnt_in;
         line_ff    <= line_in;
         cur_pix_ff <= cur_pix_in;
         pix0_ff    <= pix0_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/ws2812_led_chain_driver_core.sv -----
// Top level of the WS2812 LED chain driver: configuration registers, store
// clearing, handshakes and the result register.
// Depends on wsled_pkg, wsled_pixel_mem and wsled_serializer.
//
//   Port group   Direction  Handshake          Payload
//   req_*        in         req_valid/stall    command, led_index, color
//   rsp_*        out        rsp_valid/stall    pin_level, busy_res
//   csr_*        in         csr_wr_en          csr_index, csr_wdata
//
// One request is accepted every clock while req_stall is low; its result is
// registered in the output register on the next clock. The segment timer and
// pixel prefetch run from one store read port.
// After reset a clearing pass zeroes the pixel store with req_stall high;
// configuration writes are taken during it.
// req_stall follows rsp_stall while a result waits in the output register.
`default_nettype none

module ws2812_led_chain_driver_core #(
   parameter int MAX_LEDS = wsled_pkg::MAX_LEDS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [1:0]                    req_command,
   input  wire logic [7:0]                    req_led_index,
   input  wire logic [23:0]                   req_color,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_pin_level,
   output logic                               rsp_busy_res,
   input  wire logic                          csr_wr_en,
   input  wire logic [wsled_pkg::CSR_IW-1:0]  csr_index,
   input  wire logic [wsled_pkg::CSR_DW-1:0]  csr_wdata
);

   import wsled_pkg::*;

   localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

   cfg_type   cfg_ff, cfg_in;
   stat_type  stat;
   logic          clr_active_ff;
   logic [AW-1:0] clr_addr_ff;
   logic          rsp_valid_ff, rsp_pin_level_ff, rsp_busy_res_ff;
   logic          req_fire;
   logic          ser_wr_en, ser_rd_en, mem_wr_en;
   logic [AW-1:0] ser_wr_addr, ser_rd_addr, mem_wr_addr;
   logic [23:0]   ser_wr_data, mem_wr_data, rd_data;

   // Handshakes.
   assign req_stall = clr_active_ff || (rsp_valid_ff && rsp_stall);
   assign req_fire  = req_valid && !req_stall;

   // Configuration register writes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_LED_COUNT:       cfg_in.led_count       = csr_wdata[8:0];
            CSR_ONE_HIGH_TICKS:  cfg_in.one_high_ticks  = csr_wdata;
            CSR_ONE_LOW_TICKS:   cfg_in.one_low_ticks   = csr_wdata;
            CSR_ZERO_HIGH_TICKS: cfg_in.zero_high_ticks = csr_wdata;
            CSR_ZERO_LOW_TICKS:  cfg_in.zero_low_ticks  = csr_wdata;
            CSR_LATCH_TICKS:     cfg_in.latch_ticks     = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.led_count       <= LED_COUNT_RST;
         cfg_ff.one_high_ticks  <= ONE_HIGH_TICKS_RST;
         cfg_ff.one_low_ticks   <= ONE_LOW_TICKS_RST;
         cfg_ff.zero_high_ticks <= ZERO_HIGH_TICKS_RST;
         cfg_ff.zero_low_ticks  <= ZERO_LOW_TICKS_RST;
         cfg_ff.latch_ticks     <= LATCH_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Clearing pass over the pixel store after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
      end else if (clr_active_ff) begin
         if (clr_addr_ff == AW'(MAX_LEDS - 1)) begin
            clr_active_ff <= 1'b0;
         end else begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   assign mem_wr_en   = clr_active_ff || ser_wr_en;
   assign mem_wr_addr = clr_active_ff ? clr_addr_ff : ser_wr_addr;
   assign mem_wr_data = clr_active_ff ? 24'd0 : ser_wr_data;

   wsled_pixel_mem #(
      .DEPTH (MAX_LEDS),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (ser_rd_en),
      .rd_addr (ser_rd_addr),
      .rd_data (rd_data)
   );

   wsled_serializer #(
      .MAX_LEDS (MAX_LEDS)
   ) u_ser (
      .clock         (clock),
      .reset         (reset),
      .req_fire      (req_fire),
      .req_command   (req_command),
      .req_led_index (req_led_index),
      .req_color     (req_color),
      .cfg           (cfg_ff),
      .rd_data       (rd_data),
      .wr_en         (ser_wr_en),
      .wr_addr       (ser_wr_addr),
      .wr_data       (ser_wr_data),
      .rd_en         (ser_rd_en),
      .rd_addr       (ser_rd_addr),
      .stat          (stat)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_pin_level_ff <= stat.pin_next;
         rsp_busy_res_ff  <= stat.busy_next;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pin_level = rsp_pin_level_ff;
   assign rsp_busy_res  = rsp_busy_res_ff;

`ifndef SYNTHESIS
   // The line is only driven high inside a frame.
   a_pin_needs_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_pin_level || rsp_busy_res))
      else $error("data line high in a result that reports idle");

   // The pixel store is never written while a frame or latch is running.
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> !stat.busy)
      else $error("pixel store written while busy");

   // Nothing starts before the clearing pass is over.
   a_idle_while_clear: assert property (@(posedge clock) disable iff (reset)
      clr_active_ff |=> !stat.busy)
      else $error("sequencer busy during the clearing pass");
`endif

endmodule

`default_nettype wire

// ----- tb/ws2812_led_chain_driver_core_test.sv -----
// Self-checking testbench for the WS2812 LED chain driver core.
// Depends on wsled_pkg and ws2812_led_chain_driver_core; a built-in line
// predictor checks every response against the requests accepted.
`timescale 1ns / 100ps

module ws2812_led_chain_driver_core_test;
   import wsled_pkg::*;

   // Register indexes that decode to nothing.
   localparam logic [CSR_IW-1:0] CSR_SPARE_LO = CSR_LATCH_TICKS + CSR_IW'(1);
   localparam logic [CSR_IW-1:0] CSR_SPARE_HI = {CSR_IW{1'b1}};

   typedef struct {
      cmd_type     cmd;
      logic [7:0]  idx;
      logic [23:0] color;
   } led_req_type;

   typedef struct {
      logic pin;
      logic busy;
   } line_state_type;

   typedef enum {STALL_NONE, STALL_LIGHT, STALL_HALF, STALL_HEAVY} stall_mode_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_command = '0;
   logic [7:0]        req_led_index = '0;
   logic [23:0]       req_color = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_pin_level;
   logic              rsp_busy_res;
   logic              csr_wr_en = 1'b0;
   logic [CSR_IW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_wdata = '0;

   ws2812_led_chain_driver_core uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_led_index(req_led_index),
      .req_color(req_color),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pin_level(rsp_pin_level),
      .rsp_busy_res(rsp_busy_res),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Request and response bookkeeping.
   led_req_type    pending_reqs[$];
   line_state_type expected_lines[$];
   int          error_count = 0;
   int          accepted_count = 0;
   int          queued_count = 0;
   int          frames_started = 0;
   int          latches_started = 0;
   int          pixels_kept = 0;

   // Traffic shaping knobs, set per phase by the stimulus.
   bit             steady = 1'b0;
   stall_mode_type stall_mode = STALL_NONE;
   int          gap_left = 0;
   int          burst_left = 0;
   logic [15:0] stall_pattern = '0;
   logic [3:0]  stall_pos = '0;

   // Predictor state and its copy of the configuration.
   logic [23:0] pixel_mem [MAX_LEDS_DEF];
   phase_type   line_phase;
   int          led_ptr;
   int          bit_pos;
   logic [15:0] seg_left;
   logic        line_hi;
   logic [8:0]  cfg_leds;
   logic [15:0] cfg_one_hi;
   logic [15:0] cfg_one_lo;
   logic [15:0] cfg_zero_hi;
   logic [15:0] cfg_zero_lo;
   logic [15:0] cfg_latch;

   // A zero duration still lasts one tick.
   function automatic logic [15:0] span(input logic [15:0] t);
      return (t == 16'd0) ? 16'd1 : t;
   endfunction

   // LEDs actually sent, clipped to the store size.
   function automatic int active_leds();
      return (int'(cfg_leds) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(cfg_leds);
   endfunction

   function automatic logic current_bit();
      logic [23:0] pix;
      pix = pixel_mem[led_ptr % MAX_LEDS_DEF];
      return pix[23 - (bit_pos % BITS_PER_PIXEL)];
   endfunction

   function automatic void start_bit();
      line_hi = 1'b1;
      seg_left = span(current_bit() ? cfg_one_hi : cfg_zero_hi);
   endfunction

   // Applies one request to the predictor and returns the line state after it.
   function automatic line_state_type predict_line(input logic [1:0] code,
                                                   input logic [7:0] idx,
                                                   input logic [23:0] color);
      line_state_type res;
      logic           idle;
      idle = (line_phase == PH_IDLE);
      case (cmd_type'(code))
         CMD_WRITE: begin
            if (idle && int'(idx) < active_leds()) begin
               pixel_mem[idx] = {color[15:8], color[23:16], color[7:0]};
               pixels_kept++;
            end
         end
         CMD_SEND: begin
            if (idle && active_leds() > 0) begin
               line_phase = PH_SEND;
               led_ptr = 0;
               bit_pos = 0;
               start_bit();
               frames_started++;
            end
         end
         CMD_LATCH: begin
            if (idle) begin
               line_phase = PH_LATCH;
               line_hi = 1'b0;
               seg_left = span(cfg_latch);
               latches_started++;
            end
         end
         default: begin
            // One tick of time: count down the segment, then move on.
            if (line_phase == PH_LATCH) begin
               if (seg_left > 0) seg_left--;
               if (seg_left == 0) line_phase = PH_IDLE;
            end else if (line_phase == PH_SEND) begin
               if (seg_left > 0) seg_left--;
               if (seg_left == 0) begin
                  if (line_hi) begin
                     line_hi = 1'b0;
                     seg_left = span(current_bit() ? cfg_one_lo : cfg_zero_lo);
                  end else begin
                     bit_pos++;
                     if (bit_pos >= BITS_PER_PIXEL) begin
                        bit_pos = 0;
                        led_ptr++;
                     end
                     if (led_ptr >= active_leds()) begin
                        line_phase = PH_IDLE;
                        line_hi = 1'b0;
                        led_ptr = 0;
                        bit_pos = 0;
                        seg_left = '0;
                     end else begin
                        start_bit();
                     end
                  end
               end
            end
         end
      endcase
      res.pin = line_hi;
      res.busy = (line_phase != PH_IDLE);
      return res;
   endfunction

   // Counts a failure and reports the first few of them.
   function automatic void flag_error(input string msg);
      error_count++;
      if (error_count <= 10) $display("mismatch: %s", msg);
   endfunction

   task automatic queue_req(input cmd_type cmd, input logic [7:0] idx,
                            input logic [23:0] color);
      led_req_type r;
      r.cmd = cmd;
      r.idx = idx;
      r.color = color;
      pending_reqs.push_back(r);
      queued_count++;
   endtask

   // Tick requests carry random unused fields.
   task automatic queue_ticks(input int n);
      repeat (n) queue_req(CMD_TICK, 8'($urandom), 24'($urandom));
   endtask

   // Writes one register on the port and in the predictor.
   task automatic write_csr(input logic [CSR_IW-1:0] idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LED_COUNT:       cfg_leds = value[8:0];
         CSR_ONE_HIGH_TICKS:  cfg_one_hi = value;
         CSR_ONE_LOW_TICKS:   cfg_one_lo = value;
         CSR_ZERO_HIGH_TICKS: cfg_zero_hi = value;
         CSR_ZERO_LOW_TICKS:  cfg_zero_lo = value;
         CSR_LATCH_TICKS:     cfg_latch = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Waits until every queued request went in and every response came back.
   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_lines.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: bursts with random gaps, payload held while stalled.
   always @(posedge clock) begin
      led_req_type next_req;
      logic        take;
      take = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (take) begin
            expected_lines.push_back(predict_line(req_command, req_led_index, req_color));
            accepted_count++;
         end
         if (req_valid && !take) begin
            // Hold the stalled request as it is.
         end else if (gap_left > 0 && !steady) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            next_req = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_command <= next_req.cmd;
            req_led_index <= next_req.idx;
            req_color <= next_req.color;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = $urandom_range(0, 6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response stall driver: a 16-bit pattern redrawn each time it wraps.
   always @(posedge clock) begin
      if (stall_pos == 4'd0) begin
         case (stall_mode)
            STALL_NONE:  stall_pattern = '0;
            STALL_LIGHT: stall_pattern = 16'($urandom & $urandom & $urandom);
            STALL_HALF:  stall_pattern = 16'($urandom);
            default:     stall_pattern = 16'($urandom | $urandom);
         endcase
      end
      rsp_stall <= stall_pattern[stall_pos];
      stall_pos = stall_pos + 4'd1;
   end

   // Response monitor: each response against the oldest expectation.
   always @(posedge clock) begin
      line_state_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_lines.size() == 0) begin
            flag_error($sformatf("response pin=%b busy=%b with none expected",
                                 rsp_pin_level, rsp_busy_res));
         end else begin
            want = expected_lines.pop_front();
            if (rsp_pin_level !== want.pin || rsp_busy_res !== want.busy)
               flag_error($sformatf("pin exp %b got %b, busy exp %b got %b",
                                    want.pin, rsp_pin_level, want.busy, rsp_busy_res));
         end
      end
   end

   // Stimulus: directed cases, extremes, then random rounds.
   initial begin
      int eff;
      int cost;
      int target;
      int round_start;
      int random_start;

      foreach (pixel_mem[i]) pixel_mem[i] = '0;
      line_phase = PH_IDLE;
      led_ptr = 0;
      bit_pos = 0;
      seg_left = '0;
      line_hi = 1'b0;
      cfg_leds = LED_COUNT_RST;
      cfg_one_hi = ONE_HIGH_TICKS_RST;
      cfg_one_lo = ONE_LOW_TICKS_RST;
      cfg_zero_hi = ZERO_HIGH_TICKS_RST;
      cfg_zero_lo = ZERO_LOW_TICKS_RST;
      cfg_latch = LATCH_TICKS_RST;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Short timings so a one and a zero look different; taken during the clear pass.
      write_csr(CSR_LED_COUNT, 16'd1);
      write_csr(CSR_ONE_HIGH_TICKS, 16'd2);
      write_csr(CSR_ONE_LOW_TICKS, 16'd0);
      write_csr(CSR_ZERO_HIGH_TICKS, 16'd1);
      write_csr(CSR_ZERO_LOW_TICKS, 16'd2);
      write_csr(CSR_LATCH_TICKS, 16'd2);

      // Idle tick, color extremes, out-of-range writes, requests while busy.
      @(negedge clock);
      queue_req(CMD_TICK, 8'hFF, 24'hFFFFFF);
      queue_req(CMD_WRITE, 8'd0, 24'hFFFFFF);
      queue_req(CMD_WRITE, 8'd0, 24'h000000);
      queue_req(CMD_WRITE, 8'd0, 24'h00FF00);
      queue_req(CMD_WRITE, 8'd1, 24'h123456);
      queue_req(CMD_WRITE, 8'd255, 24'hFFFFFF);
      queue_req(CMD_SEND, 8'd0, 24'h0);
      queue_req(CMD_WRITE, 8'd0, 24'h000000);
      queue_req(CMD_SEND, 8'hFF, 24'hFFFFFF);
      queue_req(CMD_LATCH, 8'h00, 24'h000000);
      queue_ticks(75);
      queue_req(CMD_LATCH, 8'h5A, 24'hA5A5A5);
      queue_ticks(3);
      wait_for_drain();

      // No LEDs: a send does nothing and every write is out of range.
      write_csr(CSR_LED_COUNT, 16'd0);
      @(negedge clock);
      queue_req(CMD_SEND, 8'd0, 24'h0);
      queue_req(CMD_WRITE, 8'd0, 24'hA5A5A5);
      queue_ticks(1);
      wait_for_drain();

      // Zero latch time, spare register indexes, then shrink a running frame.
      write_csr(CSR_LED_COUNT, 16'd3);
      write_csr(CSR_LATCH_TICKS, 16'd0);
      write_csr(CSR_SPARE_LO, 16'hFFFF);
      write_csr(CSR_SPARE_HI, 16'h0001);
      @(negedge clock);
      queue_req(CMD_WRITE, 8'd2, 24'h5A5A5A);
      queue_req(CMD_LATCH, 8'd0, 24'h0);
      queue_ticks(2);
      queue_req(CMD_SEND, 8'd0, 24'h0);
      queue_ticks(80);
      wait_for_drain();
      write_csr(CSR_LED_COUNT, 16'd1);
      @(negedge clock);
      queue_ticks(10);
      wait_for_drain();

      // Extremes run back to back with light response stalls.
      steady = 1'b1;
      stall_mode = STALL_LIGHT;

      // Oversized LED count is clipped to the full store: the last index takes
      // a write, and a frame over the whole store is cut short to one pixel.
      write_csr(CSR_LED_COUNT, 16'hFFFF);
      write_csr(CSR_ONE_HIGH_TICKS, 16'd0);
      write_csr(CSR_ONE_LOW_TICKS, 16'd0);
      write_csr(CSR_ZERO_HIGH_TICKS, 16'd0);
      write_csr(CSR_ZERO_LOW_TICKS, 16'd0);
      @(negedge clock);
      queue_req(CMD_WRITE, 8'd255, 24'hFFFFFF);
      queue_req(CMD_WRITE, 8'd128, 24'($urandom));
      queue_req(CMD_WRITE, 8'd1, 24'h00FF00);
      queue_req(CMD_SEND, 8'd0, 24'h0);
      queue_ticks(20);
      wait_for_drain();
      write_csr(CSR_LED_COUNT, 16'd1);
      @(negedge clock);
      queue_ticks(BITS_PER_PIXEL * 2 + 4);
      wait_for_drain();

      // Full-scale zero timings left unused by a one bit, then the zero
      // timings shortened mid-frame for the rest of the pixel.
      write_csr(CSR_ONE_HIGH_TICKS, 16'd40);
      write_csr(CSR_ONE_LOW_TICKS, 16'd30);
      write_csr(CSR_ZERO_HIGH_TICKS, 16'hFFFF);
      write_csr(CSR_ZERO_LOW_TICKS, 16'hFFFF);
      @(negedge clock);
      queue_req(CMD_WRITE, 8'd0, 24'h008000);
      queue_req(CMD_SEND, 8'd0, 24'h0);
      queue_ticks(40);
      wait_for_drain();
      write_csr(CSR_ZERO_HIGH_TICKS, 16'd0);
      write_csr(CSR_ZERO_LOW_TICKS, 16'd0);
      @(negedge clock);
      queue_ticks(30 + 23 * 2 + 3);
      wait_for_drain();

      // A latch period with a count past eight bits.
      write_csr(CSR_LATCH_TICKS, 16'd300);
      @(negedge clock);
      queue_req(CMD_LATCH, 8'd0, 24'h0);
      queue_ticks(300 + 2);
      wait_for_drain();

      // Random rounds: mostly complete frames with random pixels, plus noise.
      random_start = queued_count;
      while (queued_count - random_start < 300) begin
         wait_for_drain();
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         steady = ($urandom_range(0, 3) == 0);
         case ($urandom_range(0, 9))
            0:       write_csr(CSR_LED_COUNT, 16'd0);
            1:       write_csr(CSR_LED_COUNT, 16'd3);
            default: write_csr(CSR_LED_COUNT, 16'($urandom_range(1, 2)));
         endcase
         write_csr(CSR_ONE_HIGH_TICKS, 16'($urandom_range(0, 3)));
         write_csr(CSR_ONE_LOW_TICKS, 16'($urandom_range(0, 2)));
         write_csr(CSR_ZERO_HIGH_TICKS, 16'($urandom_range(0, 2)));
         write_csr(CSR_ZERO_LOW_TICKS, 16'($urandom_range(0, 3)));
         write_csr(CSR_LATCH_TICKS, 16'($urandom_range(0, 5)));
         if ($urandom_range(0, 3) == 0)
            write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, 16'($urandom));
         @(negedge clock);
         eff = active_leds();
         cost = int'(span(cfg_one_hi) > span(cfg_zero_hi) ? span(cfg_one_hi) : span(cfg_zero_hi))
              + int'(span(cfg_one_lo) > span(cfg_zero_lo) ? span(cfg_one_lo) : span(cfg_zero_lo));
         target = $urandom_range(60, 120);
         round_start = queued_count;
         while (queued_count - round_start < target) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5: begin
                  repeat ($urandom_range(1, eff + 1)) begin
                     if ($urandom_range(0, 7) == 0)
                        queue_req(CMD_WRITE, 8'($urandom), 24'($urandom));
                     else
                        queue_req(CMD_WRITE, 8'($urandom_range(0, eff)), 24'($urandom));
                  end
                  queue_req(CMD_SEND, 8'($urandom), 24'($urandom));
                  if ($urandom_range(0, 5) == 0)
                     queue_ticks(eff * BITS_PER_PIXEL * cost / 2);
                  else
                     queue_ticks(eff * BITS_PER_PIXEL * cost + $urandom_range(0, 4));
                  if ($urandom_range(0, 2) == 0) begin
                     queue_req(CMD_LATCH, 8'($urandom), 24'($urandom));
                     queue_ticks(int'(span(cfg_latch)) + $urandom_range(0, 2));
                  end
               end
               6, 7: begin
                  repeat ($urandom_range(1, 8))
                     queue_req(cmd_type'(2'($urandom)), 8'($urandom), 24'($urandom));
               end
               8: begin
                  queue_req(CMD_LATCH, 8'($urandom), 24'($urandom));
                  queue_ticks(int'(span(cfg_latch)) + $urandom_range(0, 2));
               end
               default: queue_ticks($urandom_range(1, 10));
            endcase
         end
      end

      // Drain, give the output register time to show any stray response.
      wait_for_drain();
      repeat (20) @(posedge clock);
      if (expected_lines.size() != 0)
         flag_error($sformatf("%0d responses never arrived", expected_lines.size()));
      $display("Accepted %0d requests: %0d frames sent, %0d latch periods, %0d pixels stored.",
               accepted_count, frames_started, latches_started, pixels_kept);
      $display("Failures counted: %0d.", error_count);
      if (error_count == 0)
         $display("[ws2812_led_chain_driver_core] OK");
      else
         $display("[ws2812_led_chain_driver_core] ERROR");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #50_000_000;
      $display("[ws2812_led_chain_driver_core] ERROR");
      $finish;
   end

endmodule
